### hw/rtl/ptdq_pkg.sv
package ptdq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_CORES   = 8;
   localparam int CORE_W      = 4;
   localparam int ID_W        = 16;
   localparam int PRIO_W      = 8;
   localparam int TIME_W      = 16;
   localparam int STATUS_W    = 2;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DISPATCHED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 2'd3;

   localparam logic CMD_INSERT   = 1'b0;
   localparam logic CMD_DISPATCH = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic insert;
      logic pop;
      logic emit_head;
      logic emit_zero;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic last_one;
   } dp_status_type;

endpackage

### hw/rtl/priority_task_dispatch_queue_top.sv
// Sorted task queue of QUEUE_DEPTH entries kept in descending priority, with
// equal priorities in arrival order. A request is taken when start is high and
// busy is low; each response shows for exactly one cycle with rsp_valid high
// and cannot be held off, so capture it on that cycle. An insert request
// shifts the row of queue cells in one step; its single response (inserted,
// or dropped when full) appears on the following cycle, and busy stays low so
// the next request can follow right away. A dispatch request keeps busy high
// while it emits k responses back to back, each registered in the cycle after
// its pop, one response per core starting at core 1, where k is the lesser of
// the clamped core count and the stored tasks; the first passes through the
// state register and then the response register. The cell row pops one head
// entry per cycle, which sets that rate, and a new request can be taken at the
// edge after busy drops. A dispatch on an empty queue gives a single empty
// response on the following cycle. rsp_last marks the final response of
// every request. Write the core count through csr_ only while no request is in
// flight; 0 is served as one core and values above MAX_CORES as MAX_CORES.
module priority_task_dispatch_queue_top
   import ptdq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [ID_W-1:0]     req_task_id,
   input  logic [PRIO_W-1:0]   req_task_priority,
   input  logic [TIME_W-1:0]   req_run_time,
   // response channel
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CORE_W-1:0]   rsp_core_number,
   output logic [ID_W-1:0]     rsp_out_task_id,
   output logic [TIME_W-1:0]   rsp_out_run_time,
   output logic                rsp_last,
   // configuration
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CORE_W-1:0]   csr_num_cores
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // always take configuration writes; send them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // sequence requests, count cores, hold the response control fields
   ptdq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_cmd         (req_cmd),
      .csr_valid       (csr_valid),
      .csr_num_cores   (csr_num_cores),
      .status          (status),
      .cmd             (cmd),
      .busy            (busy),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_core_number (rsp_core_number),
      .rsp_last        (rsp_last)
   );

   // hold the sorted cell row, fill count and response payload
   ptdq_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .task_id       (req_task_id),
      .task_priority (req_task_priority),
      .run_time      (req_run_time),
      .status        (status),
      .rsp_task_id   (rsp_out_task_id),
      .rsp_run_time  (rsp_out_run_time)
   );

endmodule

### hw/rtl/ptdq_dpath.sv
module ptdq_dpath
   import ptdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctl_cmd_type       cmd,
   input  logic [ID_W-1:0]   task_id,
   input  logic [PRIO_W-1:0] task_priority,
   input  logic [TIME_W-1:0] run_time,
   output dp_status_type     status,
   output logic [ID_W-1:0]   rsp_task_id,
   output logic [TIME_W-1:0] rsp_run_time
);

   logic [ID_W-1:0]   id_ff   [QUEUE_DEPTH];
   logic [ID_W-1:0]   id_in   [QUEUE_DEPTH];
   logic [PRIO_W-1:0] prio_ff [QUEUE_DEPTH];
   logic [PRIO_W-1:0] prio_in [QUEUE_DEPTH];
   logic [TIME_W-1:0] time_ff [QUEUE_DEPTH];
   logic [TIME_W-1:0] time_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] keep;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ID_W-1:0]   out_id_ff, out_id_in;
   logic [TIME_W-1:0] out_time_ff, out_time_in;

   // a cell keeps its entry when it holds a task of equal or higher priority
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         keep[i] = (FILL_W'(i) < fill_ff) && (prio_ff[i] >= task_priority);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         id_in[i]   = id_ff[i];
         prio_in[i] = prio_ff[i];
         time_in[i] = time_ff[i];
         if (cmd.insert) begin
            if (!keep[i]) begin
               if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
                  id_in[i]   = task_id;
                  prio_in[i] = task_priority;
                  time_in[i] = run_time;
               end else begin
                  id_in[i]   = id_ff[(i == 0) ? 0 : i - 1];
                  prio_in[i] = prio_ff[(i == 0) ? 0 : i - 1];
                  time_in[i] = time_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end else if (cmd.pop && i < QUEUE_DEPTH - 1) begin
            id_in[i]   = id_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            prio_in[i] = prio_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            time_in[i] = time_ff[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.insert) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (cmd.pop) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_comb begin
      out_id_in   = out_id_ff;
      out_time_in = out_time_ff;
      if (cmd.emit_head) begin
         out_id_in   = id_ff[0];
         out_time_in = time_ff[0];
      end else if (cmd.emit_zero) begin
         out_id_in   = '0;
         out_time_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         id_ff[i]   <= id_in[i];
         prio_ff[i] <= prio_in[i];
         time_ff[i] <= time_in[i];
      end
      out_id_ff   <= out_id_in;
      out_time_ff <= out_time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign status.empty    = (fill_ff == '0);
   assign status.full     = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign status.last_one = (fill_ff == FILL_W'(1));
   assign rsp_task_id     = out_id_ff;
   assign rsp_run_time    = out_time_ff;

endmodule

### hw/rtl/ptdq_ctrl.sv
module ptdq_ctrl
   import ptdq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_cmd,
   input  logic                csr_valid,
   input  logic [CORE_W-1:0]   csr_num_cores,
   input  dp_status_type       status,
   output ctl_cmd_type         cmd,
   output logic                busy,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [CORE_W-1:0]   rsp_core_number,
   output logic                rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DISP = 1'b1;

   logic                state_ff, state_in;
   logic [CORE_W-1:0]   num_cores_ff, num_cores_in;
   logic [CORE_W-1:0]   core_cnt_ff, core_cnt_in;
   logic [CORE_W-1:0]   core_lim_ff, core_lim_in;
   logic                valid_ff, valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CORE_W-1:0]   core_ff, core_in;
   logic                last_ff, last_in;
   logic                accept;
   logic                disp_last;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign disp_last = (core_cnt_ff == core_lim_ff) || status.last_one;

   // config write: plain capture
   always_comb begin
      num_cores_in = num_cores_ff;
      if (csr_valid) begin
         num_cores_in = csr_num_cores;
      end
   end

   always_comb begin
      state_in    = state_ff;
      core_cnt_in = core_cnt_ff;
      core_lim_in = core_lim_ff;
      valid_in    = 1'b0;
      status_in   = status_ff;
      core_in     = core_ff;
      last_in     = last_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_INSERT) begin
                  cmd.insert    = !status.full;
                  cmd.emit_zero = 1'b1;
                  valid_in      = 1'b1;
                  status_in     = status.full ? STATUS_DROPPED : STATUS_INSERTED;
                  core_in       = '0;
                  last_in       = 1'b1;
               end else if (status.empty) begin
                  cmd.emit_zero = 1'b1;
                  valid_in      = 1'b1;
                  status_in     = STATUS_EMPTY;
                  core_in       = '0;
                  last_in       = 1'b1;
               end else begin
                  state_in    = ST_DISP;
                  core_cnt_in = CORE_W'(1);
                  if (num_cores_ff == '0) begin
                     core_lim_in = CORE_W'(1);
                  end else if (num_cores_ff > CORE_W'(MAX_CORES)) begin
                     core_lim_in = CORE_W'(MAX_CORES);
                  end else begin
                     core_lim_in = num_cores_ff;
                  end
               end
            end
         end
         ST_DISP: begin
            cmd.pop       = 1'b1;
            cmd.emit_head = 1'b1;
            valid_in      = 1'b1;
            status_in     = STATUS_DISPATCHED;
            core_in       = core_cnt_ff;
            last_in       = disp_last;
            core_cnt_in   = core_cnt_ff + CORE_W'(1);
            if (disp_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_cores_ff <= CORE_W'(1);
         valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_cores_ff <= num_cores_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      core_cnt_ff <= core_cnt_in;
      core_lim_ff <= core_lim_in;
      status_ff   <= status_in;
      core_ff     <= core_in;
      last_ff     <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_core_number = core_ff;
   assign rsp_last        = last_ff;

endmodule

### hw/rtl/ptdq_check.sv
module ptdq_check
   import ptdq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                req_cmd,
   input logic                rsp_valid,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [CORE_W-1:0]   rsp_core_number,
   input logic [ID_W-1:0]     rsp_out_task_id,
   input logic [TIME_W-1:0]   rsp_out_run_time,
   input logic                rsp_last
);

   // an insert answers on the very next cycle with a single final response
   a_insert_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_INSERT) |=> (rsp_valid && rsp_last))
      else $error("insert request without next-cycle final response");

   // non-dispatch responses carry no task and end the request
   a_nodisp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_DISPATCHED) |->
         (rsp_last && rsp_core_number == '0 && rsp_out_task_id == '0
          && rsp_out_run_time == '0))
      else $error("non-dispatch response with payload or without last");

   // dispatch responses come back to back with increasing core numbers
   a_disp_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_DISPATCHED && !rsp_last) |=>
         (rsp_valid && rsp_status == STATUS_DISPATCHED
          && rsp_core_number == $past(rsp_core_number) + CORE_W'(1)))
      else $error("dispatch burst broken");

   // no request is taken while a dispatch burst is still running
   a_busy_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_DISPATCHED && !rsp_last) |-> busy)
      else $error("idle during dispatch burst");

endmodule

bind priority_task_dispatch_queue_top ptdq_check u_ptdq_check (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_core_number  (rsp_core_number),
   .rsp_out_task_id  (rsp_out_task_id),
   .rsp_out_run_time (rsp_out_run_time),
   .rsp_last         (rsp_last)
);

### tb/tb.sv
module tb;
   import ptdq_pkg::*;

   // One response as it shows on the rsp_ ports.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CORE_W-1:0]   core;
      logic [ID_W-1:0]     task_id;
      logic [TIME_W-1:0]   run_time;
      logic                last;
   } task_rsp_type;

   // One row of the directed table: a request, or a core count write.
   typedef struct packed {
      bit                  is_cfg;
      logic [CORE_W-1:0]   cores;
      logic                cmd;
      logic [ID_W-1:0]     task_id;
      logic [PRIO_W-1:0]   prio;
      logic [TIME_W-1:0]   run_time;
      bit                  fixed;
      logic [STATUS_W-1:0] status;
   } step_row_type;

   localparam bit ROW_REQ   = 1'b0;
   localparam bit ROW_CFG   = 1'b1;
   localparam bit BY_MODEL  = 1'b0;
   localparam bit FIXED     = 1'b1;
   localparam int N_ROWS    = 25;
   localparam int N_SEGS    = 6;
   localparam int SEG_ITEMS = 25;
   localparam int TAIL      = 12;
   localparam int STALL_LIMIT = 3000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_cmd = CMD_INSERT;
   logic [ID_W-1:0]     req_task_id = '0;
   logic [PRIO_W-1:0]   req_task_priority = '0;
   logic [TIME_W-1:0]   req_run_time = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [CORE_W-1:0]   rsp_core_number;
   logic [ID_W-1:0]     rsp_out_task_id;
   logic [TIME_W-1:0]   rsp_out_run_time;
   logic                rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CORE_W-1:0]   csr_num_cores = '0;

   // Hand a fixed expectation along with the request it belongs to.
   bit                  row_fixed = BY_MODEL;
   logic [STATUS_W-1:0] row_status = STATUS_INSERTED;

   // Shadow copy of the sorted store and the core count.
   logic [ID_W-1:0]     model_ids   [QUEUE_DEPTH];
   logic [PRIO_W-1:0]   model_prios [QUEUE_DEPTH];
   logic [TIME_W-1:0]   model_times [QUEUE_DEPTH];
   int                  model_fill = 0;
   logic [CORE_W-1:0]   model_cores = 4'd1;

   task_rsp_type fresh_results[$];
   task_rsp_type pending_results[$];

   int idle_pct = 11;
   int sent_count = 0;
   int done_count = 0;
   int mismatches = 0;
   int stall_cycles = 0;
   int n_requests = 0;
   int n_inserted = 0;
   int n_dropped = 0;
   int n_empty = 0;
   int n_dispatched = 0;
   int n_cfg_writes = 0;

   step_row_type directed_steps [N_ROWS] = '{
      // dispatch on an empty queue; insert fields are ignored
      '{ROW_REQ, 4'd0, CMD_DISPATCH, 16'hFFFF, 8'hFF, 16'hFFFF, FIXED, STATUS_EMPTY},
      // field extremes
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0000, 8'h00, 16'h0000, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'hFFFF, 8'hFF, 16'hFFFF, FIXED, STATUS_INSERTED},
      // ties at several levels must leave in arrival order
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0101, 8'h80, 16'h0011, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0102, 8'h80, 16'h0022, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0103, 8'h00, 16'h0033, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0104, 8'hFF, 16'h0044, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0105, 8'h7F, 16'h0055, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0106, 8'h81, 16'h0066, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0107, 8'h80, 16'h0077, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h5555, 8'h55, 16'hAAAA, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'hAAAA, 8'hAA, 16'h5555, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0108, 8'h01, 16'h0088, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0109, 8'hFE, 16'h0099, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h010A, 8'h80, 16'h00AA, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h010B, 8'h00, 16'h00BB, FIXED, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h010C, 8'h40, 16'h00CC, FIXED, STATUS_INSERTED},
      // store is full now: drop even the top priority
      '{ROW_REQ, 4'd0, CMD_INSERT, 16'h0F0F, 8'hFF, 16'hF0F0, FIXED, STATUS_DROPPED},
      // too many cores is clamped to the maximum
      '{ROW_CFG, 4'd15, CMD_INSERT, 16'h0000, 8'h00, 16'h0000, BY_MODEL, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_DISPATCH, 16'h0000, 8'h00, 16'h0000, BY_MODEL, STATUS_INSERTED},
      // zero cores is served as one
      '{ROW_CFG, 4'd0, CMD_INSERT, 16'h0000, 8'h00, 16'h0000, BY_MODEL, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_DISPATCH, 16'h5A5A, 8'hA5, 16'h5A5A, BY_MODEL, STATUS_INSERTED},
      // eight cores but only seven tasks left: stop early
      '{ROW_CFG, 4'd8, CMD_INSERT, 16'h0000, 8'h00, 16'h0000, BY_MODEL, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_DISPATCH, 16'h0000, 8'h00, 16'h0000, BY_MODEL, STATUS_INSERTED},
      '{ROW_REQ, 4'd0, CMD_DISPATCH, 16'h0000, 8'h00, 16'h0000, FIXED, STATUS_EMPTY}
   };

   priority_task_dispatch_queue_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_run_time      (req_run_time),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_core_number   (rsp_core_number),
      .rsp_out_task_id   (rsp_out_task_id),
      .rsp_out_run_time  (rsp_out_run_time),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_num_cores     (csr_num_cores)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Apply one request to the shadow store and append its responses to fresh_results.
   function automatic void predict_queue_results(input logic cmd,
                                                 input logic [ID_W-1:0] tid,
                                                 input logic [PRIO_W-1:0] prio,
                                                 input logic [TIME_W-1:0] rt);
      int slot;
      int served;
      int core;
      task_rsp_type r;
      r = '0;
      r.last = 1'b1;
      if (cmd == CMD_INSERT) begin
         if (model_fill >= QUEUE_DEPTH) begin
            r.status = STATUS_DROPPED;
         end else begin
            // go behind every entry of equal or higher priority
            slot = 0;
            while (slot < model_fill && model_prios[slot] >= prio) slot++;
            for (int i = model_fill; i > slot; i--) begin
               model_ids[i]   = model_ids[i-1];
               model_prios[i] = model_prios[i-1];
               model_times[i] = model_times[i-1];
            end
            model_ids[slot]   = tid;
            model_prios[slot] = prio;
            model_times[slot] = rt;
            model_fill++;
            r.status = STATUS_INSERTED;
         end
         fresh_results.push_back(r);
      end else if (model_fill == 0) begin
         r.status = STATUS_EMPTY;
         fresh_results.push_back(r);
      end else begin
         served = (model_cores == 0) ? 1 :
                  (model_cores > MAX_CORES) ? MAX_CORES : int'(model_cores);
         for (core = 1; core <= served && model_fill > 0; core++) begin
            r.status   = STATUS_DISPATCHED;
            r.core     = core[CORE_W-1:0];
            r.task_id  = model_ids[0];
            r.run_time = model_times[0];
            for (int i = 1; i < model_fill; i++) begin
               model_ids[i-1]   = model_ids[i];
               model_prios[i-1] = model_prios[i];
               model_times[i-1] = model_times[i];
            end
            model_fill--;
            r.last = (core == served || model_fill == 0);
            fresh_results.push_back(r);
         end
      end
   endfunction

   function automatic void note_mismatch(input string what, input task_rsp_type want,
                                         input task_rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t %s: expected status %0d core %0d id %h time %h last %0d,",
                   " got status %0d core %0d id %h time %h last %0d"},
                  $time, what, want.status, want.core, want.task_id, want.run_time, want.last,
                  got.status, got.core, got.task_id, got.run_time, got.last);
   endfunction

   // Predict on each taken request, check each response, watch for a hang.
   always @(posedge clock) begin : scoreboard
      task_rsp_type got;
      task_rsp_type want;
      task_rsp_type fixed_rsp;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            model_cores = csr_num_cores;
            n_cfg_writes++;
            moved = 1'b1;
         end
         if (start && !busy) begin
            fresh_results.delete();
            predict_queue_results(req_cmd, req_task_id, req_task_priority, req_run_time);
            n_requests++;
            foreach (fresh_results[i]) begin
               case (fresh_results[i].status)
                  STATUS_INSERTED:   n_inserted++;
                  STATUS_DROPPED:    n_dropped++;
                  STATUS_EMPTY:      n_empty++;
                  default:           n_dispatched++;
               endcase
            end
            if (row_fixed == FIXED) begin
               fixed_rsp = '0;
               fixed_rsp.status = row_status;
               fixed_rsp.last = 1'b1;
               pending_results.push_back(fixed_rsp);
            end else begin
               foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
            end
            moved = 1'b1;
         end
         if (rsp_valid) begin
            got = '{rsp_status, rsp_core_number, rsp_out_task_id, rsp_out_run_time, rsp_last};
            moved = 1'b1;
            if (pending_results.size() == 0) begin
               note_mismatch("unexpected result", '0, got);
            end else begin
               want = pending_results.pop_front();
               if (got.status !== want.status || got.core !== want.core ||
                   got.task_id !== want.task_id || got.run_time !== want.run_time ||
                   got.last !== want.last)
                  note_mismatch("result mismatch", want, got);
               if (want.last) done_count++;
            end
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Hold start low and wait until every request has seen its last result.
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (done_count != sent_count || busy) @(posedge clock);
   endtask

   task automatic send_request(input logic cmd, input logic [ID_W-1:0] tid,
                               input logic [PRIO_W-1:0] prio, input logic [TIME_W-1:0] rt,
                               input bit fixed, input logic [STATUS_W-1:0] st);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start             <= 1'b1;
      req_cmd           <= cmd;
      req_task_id       <= tid;
      req_task_priority <= prio;
      req_run_time      <= rt;
      row_fixed         <= fixed;
      row_status        <= st;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   task automatic write_core_count(input logic [CORE_W-1:0] value);
      wait_for_drain();
      csr_valid     <= 1'b1;
      csr_num_cores <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CORE_W-1:0] seg_cores [N_SEGS];
      int seg_idle [N_SEGS];
      int seg_items;
      int n_ins;
      int n_disp;
      logic [PRIO_W-1:0] prio;

      seg_cores = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd3, 4'd5};
      seg_idle  = '{11, 11, 87, 87, 0, 0};
      seg_cores[5] = CORE_W'($urandom_range(2, 7));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      idle_pct = 11;
      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_cfg == ROW_CFG)
            write_core_count(directed_steps[i].cores);
         else
            send_request(directed_steps[i].cmd, directed_steps[i].task_id,
                         directed_steps[i].prio, directed_steps[i].run_time,
                         directed_steps[i].fixed, directed_steps[i].status);
      end

      // random bursts: fill runs (often to full) followed by a few dispatches, or now and then one random request
      for (int s = 0; s < N_SEGS; s++) begin
         write_core_count(seg_cores[s]);
         idle_pct = seg_idle[s];
         seg_items = 0;
         while (seg_items < SEG_ITEMS) begin
            if ($urandom_range(99) < 10) begin
               send_request(1'($urandom_range(1)), ID_W'($urandom_range(16'hFFFF)),
                            PRIO_W'($urandom_range(8'hFF)), TIME_W'($urandom_range(16'hFFFF)),
                            BY_MODEL, STATUS_INSERTED);
               seg_items++;
            end else begin
               n_ins  = $urandom_range(1, 18);
               n_disp = $urandom_range(1, 3);
               repeat (n_ins) begin
                  // lean on a few levels so ties are common
                  if ($urandom_range(1))
                     prio = PRIO_W'($urandom_range(3) * 8'h55);
                  else
                     prio = PRIO_W'($urandom_range(8'hFF));
                  send_request(CMD_INSERT, ID_W'($urandom_range(16'hFFFF)), prio,
                               TIME_W'($urandom_range(16'hFFFF)), BY_MODEL, STATUS_INSERTED);
               end
               repeat (n_disp)
                  send_request(CMD_DISPATCH, ID_W'($urandom_range(16'hFFFF)),
                               PRIO_W'($urandom_range(8'hFF)),
                               TIME_W'($urandom_range(16'hFFFF)), BY_MODEL, STATUS_INSERTED);
               seg_items += n_ins + n_disp;
            end
            // now and then let everything drain before going on
            if ($urandom_range(99) < 8) wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (TAIL) @(posedge clock);
      if (pending_results.size() != 0) begin
         mismatches += pending_results.size();
         $display("%0d expected results never arrived", pending_results.size());
      end
      $display("Ran %0d requests: %0d inserted, %0d dropped when full, %0d on an empty queue",
               n_requests, n_inserted, n_dropped, n_empty);
      $display("Saw %0d tasks dispatched across %0d core count writes, %0d mismatches",
               n_dispatched, n_cfg_writes, mismatches);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
